@@ sv/psd_pkg.sv @@
// Package for the point-to-segment distance unit.
// Holds word types, widths and status codes; no dependencies.
package psd_pkg;

  localparam int unsigned CoordBits = 24;
  localparam int unsigned FracBits  = 24;
  localparam int unsigned DistBits  = 49;
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned ProdBits  = 2 * DiffBits;
  localparam int unsigned SumBits   = ProdBits + 1;

  typedef enum logic [1:0] {
    StatInside = 2'd0,
    StatBefore = 2'd1,
    StatPast   = 2'd2,
    StatUnused = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] nearest_x;
    logic signed [CoordBits-1:0] nearest_y;
    logic        [DistBits-1:0]  dist_squared;
    logic        [1:0]           position_status;
  } out_word_t;

endpackage

@@ sv/point_segment_distance_unit.sv @@
// Point-to-segment distance unit: closest point, squared distance, status.
// Depends on psd_pkg.
//
// Usage: input words (query point, segment start, segment end) arrive on the
// in_valid_i/in_ready_o channel; one result word per input leaves on the
// out_valid_o/out_ready_i channel, in order.
// Pipeline: a difference stage, a product stage, a classification stage,
// FracBits (24) restoring divider stages (one quotient bit per stage), a
// scaling multiply stage, a rounding stage, a distance product stage and
// an output register.
// Throughput: one word per cycle when not stalled; the divider sets the depth.
// Stages advance independently (bubbles are squeezed out): when the receiver
// drops out_ready_i and the output register is full, a full stage holds until
// a stage ahead of it is free; in_ready_o drops only while every stage is full.
// Reset clears all valid bits; no word is in flight afterward and the block
// is ready at once.
// position_status: 0 inside, at end or zero-length, 1 before start, 2 past end.
module point_segment_distance_unit
  import psd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int unsigned NStg = FracBits + 7;

  typedef logic signed [DiffBits-1:0] dif_t;
  typedef logic signed [SumBits:0]    big_t;

  // pipeline valid bits; stage k advances when stage k+1 is free or moves
  logic [NStg-1:0] v_q;
  logic [NStg:0]   mv;

  always_comb begin
    mv[NStg] = out_ready_i || !v_q[NStg-1];
    for (int k = NStg - 1; k >= 0; k--) begin
      if (k == 0) mv[k] = mv[1] || !v_q[0];
      else        mv[k] = mv[k+1] || !v_q[k];
    end
  end
  assign in_ready_o  = mv[0];
  assign out_valid_o = v_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (mv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NStg; k++) begin
        if (mv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: differences
  dif_t dx0_q, dy0_q, ax0_q, ay0_q;
  logic signed [CoordBits-1:0] sx0_q, sy0_q, ex0_q, ey0_q, px0_q, py0_q;
  always_ff @(posedge clk_i) begin
    if (mv[0]) begin
      dx0_q <= DiffBits'(in_data_i.end_x)   - DiffBits'(in_data_i.start_x);
      dy0_q <= DiffBits'(in_data_i.end_y)   - DiffBits'(in_data_i.start_y);
      ax0_q <= DiffBits'(in_data_i.point_x) - DiffBits'(in_data_i.start_x);
      ay0_q <= DiffBits'(in_data_i.point_y) - DiffBits'(in_data_i.start_y);
      sx0_q <= in_data_i.start_x; sy0_q <= in_data_i.start_y;
      ex0_q <= in_data_i.end_x;   ey0_q <= in_data_i.end_y;
      px0_q <= in_data_i.point_x; py0_q <= in_data_i.point_y;
    end
  end

  // stage 1: four signed products
  logic signed [ProdBits-1:0] pxx_q, pyy_q, pxa_q, pya_q;
  dif_t dx1_q, dy1_q;
  logic signed [CoordBits-1:0] sx1_q, sy1_q, ex1_q, ey1_q, px1_q, py1_q;
  always_ff @(posedge clk_i) begin
    if (mv[1]) begin
      pxx_q <= dx0_q * dx0_q; pyy_q <= dy0_q * dy0_q;
      pxa_q <= dx0_q * ax0_q; pya_q <= dy0_q * ay0_q;
      dx1_q <= dx0_q; dy1_q <= dy0_q;
      sx1_q <= sx0_q; sy1_q <= sy0_q; ex1_q <= ex0_q; ey1_q <= ey0_q;
      px1_q <= px0_q; py1_q <= py0_q;
    end
  end

  // stage 2: sums, classify
  big_t num_c, len_c;
  assign num_c = big_t'(pxa_q) + big_t'(pya_q);
  assign len_c = big_t'(pxx_q) + big_t'(pyy_q);

  typedef struct packed {
    logic [SumBits-1:0]          rem;
    logic [SumBits-1:0]          len;
    logic [FracBits-1:0]         q;
    logic                        div;
    logic [1:0]                  status;
    logic                        use_end;
    dif_t                        dx;
    dif_t                        dy;
    logic signed [CoordBits-1:0] sx, sy, ex, ey, px, py;
  } dv_t;

  dv_t d2_d;
  always_comb begin
    d2_d        = '0;
    d2_d.len    = SumBits'(len_c);
    d2_d.rem    = SumBits'(num_c);
    d2_d.dx     = dx1_q; d2_d.dy = dy1_q;
    d2_d.sx     = sx1_q; d2_d.sy = sy1_q; d2_d.ex = ex1_q; d2_d.ey = ey1_q;
    d2_d.px     = px1_q; d2_d.py = py1_q;
    d2_d.status = StatInside;
    if (dx1_q == '0 && dy1_q == '0) begin
      d2_d.status = StatInside;
    end else if (num_c < 0) begin
      d2_d.status = StatBefore;
    end else if (num_c > len_c) begin
      d2_d.status = StatPast; d2_d.use_end = 1'b1;
    end else if (num_c == len_c) begin
      d2_d.use_end = 1'b1;
    end else begin
      d2_d.div = 1'b1;
    end
  end

  // divider stages: one restoring step each
  dv_t dv_q [FracBits+1];
  dv_t dv_n [FracBits];
  always_comb begin
    for (int k = 0; k < FracBits; k++) begin
      logic [SumBits:0] sh;
      sh = {dv_q[k].rem, 1'b0};
      dv_n[k] = dv_q[k];
      if (sh >= {1'b0, dv_q[k].len}) begin
        dv_n[k].rem = SumBits'(sh - {1'b0, dv_q[k].len});
        dv_n[k].q   = {dv_q[k].q[FracBits-2:0], 1'b1};
      end else begin
        dv_n[k].rem = SumBits'(sh);
        dv_n[k].q   = {dv_q[k].q[FracBits-2:0], 1'b0};
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (mv[2]) dv_q[0] <= d2_d;
    for (int k = 0; k < FracBits; k++) begin
      if (mv[k+3]) dv_q[k+1] <= dv_n[k];
    end
  end

  // scaling multiply: |d| * q
  localparam int unsigned MBits = CoordBits + FracBits;
  localparam int unsigned SM    = FracBits + 3;
  typedef struct packed {
    logic [MBits-1:0] mx, my;
    logic sgx, sgy, div, use_end;
    logic [1:0] status;
    logic signed [CoordBits-1:0] sx, sy, ex, ey, px, py;
  } ml_t;
  ml_t ml_q;
  dv_t dl;
  logic [DiffBits-1:0] amx, amy;
  assign dl  = dv_q[FracBits];
  assign amx = dl.dx[DiffBits-1] ? DiffBits'(-dl.dx) : DiffBits'(dl.dx);
  assign amy = dl.dy[DiffBits-1] ? DiffBits'(-dl.dy) : DiffBits'(dl.dy);
  always_ff @(posedge clk_i) begin
    if (mv[SM]) begin
      ml_q.mx <= MBits'(amx * dl.q);
      ml_q.my <= MBits'(amy * dl.q);
      ml_q.sgx <= dl.dx[DiffBits-1]; ml_q.sgy <= dl.dy[DiffBits-1];
      ml_q.div <= dl.div; ml_q.use_end <= dl.use_end; ml_q.status <= dl.status;
      ml_q.sx <= dl.sx; ml_q.sy <= dl.sy; ml_q.ex <= dl.ex; ml_q.ey <= dl.ey;
      ml_q.px <= dl.px; ml_q.py <= dl.py;
    end
  end

  // rounding, ties toward plus infinity: floor((s*m + half) / 2^F)
  function automatic logic signed [CoordBits-1:0] rnd_off(input logic [MBits-1:0] m,
                                                          input logic sg);
    logic signed [MBits+1:0] t;
    t = sg ? -$signed({2'b00, m}) : $signed({2'b00, m});
    t = t + ((MBits+2)'(1) <<< (FracBits - 1));
    return CoordBits'(t >>> FracBits);
  endfunction

  typedef struct packed {
    logic signed [CoordBits-1:0] nx, ny, px, py;
    logic [1:0] status;
  } rd_t;
  rd_t rd_q;
  always_ff @(posedge clk_i) begin
    if (mv[SM+1]) begin
      rd_q.px <= ml_q.px; rd_q.py <= ml_q.py; rd_q.status <= ml_q.status;
      if (ml_q.use_end) begin
        rd_q.nx <= ml_q.ex; rd_q.ny <= ml_q.ey;
      end else if (ml_q.div) begin
        rd_q.nx <= ml_q.sx + rnd_off(ml_q.mx, ml_q.sgx);
        rd_q.ny <= ml_q.sy + rnd_off(ml_q.my, ml_q.sgy);
      end else begin
        rd_q.nx <= ml_q.sx; rd_q.ny <= ml_q.sy;
      end
    end
  end

  // distance products
  typedef struct packed {
    logic [ProdBits-1:0] qx, qy;
    logic signed [CoordBits-1:0] nx, ny;
    logic [1:0] status;
  } sq_t;
  sq_t sq_q;
  dif_t ex_c, ey_c;
  assign ex_c = DiffBits'(rd_q.nx) - DiffBits'(rd_q.px);
  assign ey_c = DiffBits'(rd_q.ny) - DiffBits'(rd_q.py);
  always_ff @(posedge clk_i) begin
    if (mv[SM+2]) begin
      sq_q.qx <= ProdBits'(ex_c * ex_c);
      sq_q.qy <= ProdBits'(ey_c * ey_c);
      sq_q.nx <= rd_q.nx; sq_q.ny <= rd_q.ny; sq_q.status <= rd_q.status;
    end
  end

  out_word_t out_q;
  always_ff @(posedge clk_i) begin
    if (mv[SM+3]) begin
      out_q.nearest_x       <= sq_q.nx;
      out_q.nearest_y       <= sq_q.ny;
      out_q.dist_squared    <= DistBits'(sq_q.qx + sq_q.qy);
      out_q.position_status <= sq_q.status;
    end
  end
  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed under stall");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.position_status != StatUnused)
    else $error("unused status code");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> &v_q)
    else $error("input stalled with a free stage");
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.position_status == StatPast |-> out_data_o.dist_squared != '0)
    else $error("past-end word at zero distance");
`endif

endmodule
